FILE: sv/ctlex_pkg.sv
package ctlex_pkg;

    // token kinds
    localparam logic [3:0] KIND_EOF     = 4'd0;
    localparam logic [3:0] KIND_INT     = 4'd1;
    localparam logic [3:0] KIND_RETURN  = 4'd2;
    localparam logic [3:0] KIND_IDENT   = 4'd3;
    localparam logic [3:0] KIND_INTEGER = 4'd4;
    localparam logic [3:0] KIND_LPAREN  = 4'd5;
    localparam logic [3:0] KIND_RPAREN  = 4'd6;
    localparam logic [3:0] KIND_LBRACE  = 4'd7;
    localparam logic [3:0] KIND_RBRACE  = 4'd8;
    localparam logic [3:0] KIND_SEMI    = 4'd9;
    localparam logic [3:0] KIND_ERROR   = 4'd10;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_Z   = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_E      = 8'h65;
    localparam logic [7:0] CH_I      = 8'h69;
    localparam logic [7:0] CH_N      = 8'h6E;
    localparam logic [7:0] CH_R      = 8'h72;
    localparam logic [7:0] CH_T      = 8'h74;
    localparam logic [7:0] CH_U      = 8'h75;

    // token queue geometry
    localparam int TQ_DEPTH = 4;
    localparam int TQ_AW    = $clog2(TQ_DEPTH);
    localparam int TQ_CW    = $clog2(TQ_DEPTH + 1);

    // scan modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE    = 5'b00001,
        MODE_IDENT   = 5'b00010,
        MODE_NUMBER  = 5'b00100,
        MODE_SLASH   = 5'b01000,
        MODE_COMMENT = 5'b10000
    } t_mode;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] line;
        logic [15:0] col;
        logic [15:0] len;
        logic        last;
    } t_token;

    // tokens produced by one character
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_emit;

    function automatic logic is_letter(input logic [7:0] c);
        return (c inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z], CH_UNDER});
    endfunction

    function automatic logic num_char(input logic [7:0] c);
        return (c inside {[CH_0:CH_9]});
    endfunction

    function automatic logic ws_char(input logic [7:0] c);
        return (c inside {CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR});
    endfunction

    // kind of a single-character token
    function automatic logic [3:0] punct_kind(input logic [7:0] c);
        logic [3:0] k;
        case (c)
            CH_LPAREN: k = KIND_LPAREN;
            CH_RPAREN: k = KIND_RPAREN;
            CH_LBRACE: k = KIND_LBRACE;
            CH_RBRACE: k = KIND_RBRACE;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_ERROR;
        endcase
        return k;
    endfunction

    // bit 0: c matches "int" at pos, bit 1: c matches "return" at pos
    function automatic logic [1:0] kw_match(input logic [7:0] c, input logic [2:0] pos);
        logic int_ok;
        logic ret_ok;
        case (pos)
            3'd0: begin
                int_ok = (c == CH_I);
                ret_ok = (c == CH_R);
            end
            3'd1: begin
                int_ok = (c == CH_N);
                ret_ok = (c == CH_E);
            end
            3'd2: begin
                int_ok = (c == CH_T);
                ret_ok = (c == CH_T);
            end
            3'd3: begin
                int_ok = 1'b0;
                ret_ok = (c == CH_U);
            end
            3'd4: begin
                int_ok = 1'b0;
                ret_ok = (c == CH_R);
            end
            3'd5: begin
                int_ok = 1'b0;
                ret_ok = (c == CH_N);
            end
            default: begin
                int_ok = 1'b0;
                ret_ok = 1'b0;
            end
        endcase
        return {ret_ok, int_ok};
    endfunction

endpackage

FILE: sv/ctlex_scan.sv
module ctlex_scan #(
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [7:0]        i_char,
    output ctlex_pkg::t_emit  o_emit
);
    import ctlex_pkg::*;

    localparam logic [CW-1:0] ONE = CW'(1);

    t_mode         r_mode,  n_mode;
    logic [CW-1:0] r_line,  n_line;
    logic [CW-1:0] r_col,   n_col;
    logic [CW-1:0] r_sline, n_sline;
    logic [CW-1:0] r_scol,  n_scol;
    logic [CW-1:0] r_run,   n_run;
    logic [1:0]    r_flags, n_flags;

    t_token tok_a;
    t_token tok_b;
    logic   a_v;
    logic   b_v;
    logic   rescan;
    logic [1:0] kw_cur;

    function automatic logic [CW-1:0] sat_inc(input logic [CW-1:0] v);
        return (&v) ? v : v + ONE;
    endfunction

    function automatic logic [15:0] clamp16(input logic [CW-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (|w[31:16]) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic t_token mk_tok(input logic [3:0] k, input logic [CW-1:0] ln,
                                      input logic [CW-1:0] cl, input logic [CW-1:0] lg);
        t_token t;
        t.kind = k;
        t.line = clamp16(ln);
        t.col  = clamp16(cl);
        t.len  = clamp16(lg);
        t.last = 1'b0;
        return t;
    endfunction

    // keyword match of the incoming character at the current run position
    assign kw_cur = (r_run < CW'(6)) ? kw_match(i_char, r_run[2:0]) : 2'b00;

    // next state and tokens for one character
    always_comb begin
        n_mode  = r_mode;
        n_line  = r_line;
        n_col   = r_col;
        n_sline = r_sline;
        n_scol  = r_scol;
        n_run   = r_run;
        n_flags = r_flags;
        tok_a   = mk_tok(KIND_EOF, r_line, r_col, '0);
        tok_b   = tok_a;
        a_v     = 1'b0;
        b_v     = 1'b0;
        rescan  = 1'b0;

        // finish or extend the run in progress
        case (r_mode)
            MODE_IDENT: begin
                if (is_letter(i_char) || num_char(i_char)) begin
                    n_flags = r_flags & kw_cur;
                    n_run   = sat_inc(r_run);
                    n_col   = sat_inc(r_col);
                end else begin
                    a_v = 1'b1;
                    if (r_run == CW'(3) && r_flags[0]) begin
                        tok_a = mk_tok(KIND_INT, r_sline, r_scol, r_run);
                    end else if (r_run == CW'(6) && r_flags[1]) begin
                        tok_a = mk_tok(KIND_RETURN, r_sline, r_scol, r_run);
                    end else begin
                        tok_a = mk_tok(KIND_IDENT, r_sline, r_scol, r_run);
                    end
                    n_mode = MODE_IDLE;
                    rescan = 1'b1;
                end
            end
            MODE_NUMBER: begin
                if (num_char(i_char)) begin
                    n_run = sat_inc(r_run);
                    n_col = sat_inc(r_col);
                end else begin
                    a_v    = 1'b1;
                    tok_a  = mk_tok(KIND_INTEGER, r_sline, r_scol, r_run);
                    n_mode = MODE_IDLE;
                    rescan = 1'b1;
                end
            end
            MODE_SLASH: begin
                if (i_char == CH_SLASH) begin
                    n_col  = sat_inc(r_col);
                    n_mode = MODE_COMMENT;
                end else begin
                    a_v    = 1'b1;
                    tok_a  = mk_tok(KIND_ERROR, r_sline, r_scol, ONE);
                    n_mode = MODE_IDLE;
                    rescan = 1'b1;
                end
            end
            MODE_COMMENT: begin
                if (i_char == CH_NUL || i_char == CH_LF) begin
                    n_mode = MODE_IDLE;
                    rescan = 1'b1;
                end else begin
                    n_col = sat_inc(r_col);
                end
            end
            default: begin
                n_mode = MODE_IDLE;
                rescan = 1'b1;
            end
        endcase

        // scan the character from idle
        if (rescan) begin
            if (i_char == CH_NUL) begin
                b_v     = 1'b1;
                tok_b   = mk_tok(KIND_EOF, r_line, r_col, '0);
                n_mode  = MODE_IDLE;
                n_line  = ONE;
                n_col   = ONE;
                n_sline = ONE;
                n_scol  = ONE;
                n_run   = '0;
                n_flags = 2'b00;
            end else if (ws_char(i_char)) begin
                if (i_char == CH_LF) begin
                    n_line = sat_inc(r_line);
                    n_col  = ONE;
                end else begin
                    n_col = sat_inc(r_col);
                end
            end else if (i_char == CH_SLASH) begin
                n_sline = r_line;
                n_scol  = r_col;
                n_col   = sat_inc(r_col);
                n_mode  = MODE_SLASH;
            end else if (is_letter(i_char) || num_char(i_char)) begin
                n_flags = is_letter(i_char) ? kw_match(i_char, 3'd0) : 2'b00;
                n_sline = r_line;
                n_scol  = r_col;
                n_run   = ONE;
                n_col   = sat_inc(r_col);
                n_mode  = is_letter(i_char) ? MODE_IDENT : MODE_NUMBER;
            end else begin
                b_v   = 1'b1;
                tok_b = mk_tok(punct_kind(i_char), r_line, r_col, ONE);
                n_col = sat_inc(r_col);
            end
        end
    end

    // pack the tokens in order, last flag on the final one
    always_comb begin
        o_emit.cnt       = i_fire ? 2'({1'b0, a_v} + {1'b0, b_v}) : 2'd0;
        o_emit.tok0      = a_v ? tok_a : tok_b;
        o_emit.tok0.last = !(a_v && b_v);
        o_emit.tok1      = tok_b;
        o_emit.tok1.last = 1'b1;
    end

    // scan state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_line  <= ONE;
            r_col   <= ONE;
            r_sline <= ONE;
            r_scol  <= ONE;
            r_run   <= '0;
            r_flags <= 2'b00;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_line  <= n_line;
            r_col   <= n_col;
            r_sline <= n_sline;
            r_scol  <= n_scol;
            r_run   <= n_run;
            r_flags <= n_flags;
        end
    end

endmodule

FILE: sv/ctlex_tok_fifo.sv
module ctlex_tok_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ctlex_pkg::t_emit  i_emit,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output ctlex_pkg::t_token o_tok
);
    import ctlex_pkg::*;

    t_token            r_mem [TQ_DEPTH];
    logic [TQ_AW-1:0]  r_wr;
    logic [TQ_AW-1:0]  r_rd;
    logic [TQ_CW-1:0]  r_count;
    logic [TQ_AW-1:0]  wr_next;
    logic              pop;

    // room for the two tokens a character may produce
    assign o_room  = (r_count <= TQ_CW'(TQ_DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_ready;
    assign wr_next = r_wr + TQ_AW'(1);

    // token storage
    always_ff @(posedge i_clk) begin
        if (i_emit.cnt != 2'd0) begin
            r_mem[r_wr] <= i_emit.tok0;
        end
        if (i_emit.cnt == 2'd2) begin
            r_mem[wr_next] <= i_emit.tok1;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + TQ_AW'(i_emit.cnt);
            r_rd    <= r_rd + TQ_AW'(pop);
            r_count <= TQ_CW'(r_count + TQ_CW'(i_emit.cnt) - TQ_CW'(pop));
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= TQ_CW'(TQ_DEPTH))
        else $error("token queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_emit.cnt != 2'd0) |-> (r_count <= TQ_CW'(TQ_DEPTH - 2)))
        else $error("token push without room");

    a_pop_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_emit.cnt == 2'd0) |=> (r_count == TQ_CW'($past(r_count) - 1'b1)))
        else $error("token queue count did not drop after pop");
`endif

endmodule

FILE: sv/c_subset_token_lexer_top.sv
// channel   dir  tdata                          tuser  tlast
// s (char)  in   [7:0] char_code                -      -
// m (token) out  [3:0] token_kind, [19:4] line,  -      last_of_run
//                [35:20] col, [51:36] len
//
// one character is taken per cycle while the queue has room; each beat passes an
// input register and then a four-entry token queue on its way to the output
// between two chars that yield two tokens there is always one that yields none,
// so with the output ready the queue never lacks room and the input never stalls
// reset is synchronous and active low; it returns the scan to line 1 col 1
// a stall on the output fills the queue and then backs up into the input
module c_subset_token_lexer_top #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_code
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [55:0] o_m_tdata,   // kind, line, col, len, zero pad
    output logic        o_m_tlast
);
    import ctlex_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       fire;
    logic       room;
    t_emit      emit;
    t_token     tok;

    assign fire       = r_in_valid && room;
    assign o_s_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_char <= i_s_tdata;
        end
    end

    ctlex_scan #(
        .CW (COUNT_WIDTH)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_char  (r_in_char),
        .o_emit  (emit)
    );

    ctlex_tok_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_room  (room),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_tok   (tok)
    );

    // output beat packing
    assign o_m_tdata = {4'b0000, tok.len, tok.col, tok.line, tok.kind};
    assign o_m_tlast = tok.last;

endmodule
